/* design/dgr_pkg.sv */
// Package for the delta gap run decoder: item, result and queue record types.
// No dependencies; used by every other file of the block except dgr_stream.
`default_nettype none

package dgr_pkg;

    // Depth of the queue between front and back
    localparam int unsigned QDEPTH = 2;
    localparam int unsigned QPTR_W = 1;

    // One input item: a signed delta with the end-of-entry flag
    typedef struct packed {
        logic signed [31:0] delta_value;
        logic               is_last;
    } t_in;

    // One result item: a closed or flushed gap range
    typedef struct packed {
        logic        gap_strand;
        logic [31:0] gap_start;
        logic [31:0] gap_end;
        logic        last_range;
    } t_out;

    // Queue record: up to two ranges caused by one input item
    typedef struct packed {
        logic has_close;
        logic has_flush;
        t_out close_rng;
        t_out flush_rng;
    } t_rec;

endpackage

`default_nettype wire

/* design/dgr_stream.sv */
// Valid/ready stream interface used for the item and result channels.
// Payload type is set at instantiation; no other dependencies.
`default_nettype none

interface dgr_stream #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* design/dgr_front.sv */
// Front part: accepts deltas, tracks the pending gap run, builds queue records.
// Depends on dgr_pkg.
`default_nettype none

module dgr_front #(
    parameter int unsigned OFFSET_WIDTH = 32
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire dgr_pkg::t_in  i_data,
    output logic               o_ready,
    input  wire logic          i_q_ready,
    output logic               o_push,
    output dgr_pkg::t_rec      o_rec
);

    localparam int unsigned W  = OFFSET_WIDTH;
    // sum width: wide enough for any offset plus a 32-bit magnitude
    localparam int unsigned SW = ((W > 32) ? W : 32) + 1;

    logic         r_valid;
    logic         r_strand;
    logic [W-1:0] r_start;
    logic [W-1:0] r_end;     // saturated start + length

    logic         n_valid;
    logic         n_strand;
    logic [W-1:0] n_start;
    logic [W-1:0] n_end;

    logic          neg;
    logic          pos;
    logic [31:0]   mag;
    logic          extend;
    logic          accept;
    logic [W-1:0]  base;
    logic [SW-1:0] sum;
    logic [W-1:0]  open_off;
    logic [W-1:0]  ext_end;

    // Low 32 bits of a position, zero-extended for narrow offsets
    function automatic logic [31:0] pos32(input logic [W-1:0] v);
        logic [SW-1:0] t;
        t = SW'(v);
        return t[31:0];
    endfunction

    assign o_ready = i_q_ready;
    assign accept  = i_valid & i_q_ready;

    // Classify the delta
    assign neg = i_data.delta_value[31];
    assign pos = !neg && (i_data.delta_value != 32'sd0);
    assign mag = neg ? (~i_data.delta_value + 32'd1) : i_data.delta_value;

    assign extend = r_valid &&
        ((i_data.delta_value == 32'sd1 && r_strand) ||
         (i_data.delta_value == -32'sd1 && !r_strand));

    // Offset of a newly opened run: the pending run's end (or 0) plus magnitude
    assign base     = r_valid ? r_end : '0;
    assign sum      = SW'(base) + SW'(mag);
    assign open_off = (sum > SW'({W{1'b1}})) ? {W{1'b1}} : sum[W-1:0];

    // Extended run end, saturating
    assign ext_end = (&r_end) ? r_end : r_end + W'(1);

    // Record of the results this item causes
    always_comb begin
        o_rec.has_close            = r_valid && !extend;
        o_rec.close_rng.gap_strand = r_strand;
        o_rec.close_rng.gap_start  = pos32(r_start);
        o_rec.close_rng.gap_end    = pos32(r_end);
        o_rec.close_rng.last_range = 1'b0;
        o_rec.has_flush            = i_data.is_last;
        o_rec.flush_rng.gap_strand = extend ? r_strand : pos;
        o_rec.flush_rng.gap_start  = extend ? pos32(r_start) : pos32(open_off);
        o_rec.flush_rng.gap_end    = extend ? pos32(ext_end) : pos32(open_off);
        o_rec.flush_rng.last_range = 1'b1;
    end

    assign o_push = accept && (o_rec.has_close || o_rec.has_flush);

    // Run state update
    always_comb begin
        n_valid  = r_valid;
        n_strand = r_strand;
        n_start  = r_start;
        n_end    = r_end;
        if (accept) begin
            if (i_data.is_last) begin
                n_valid  = 1'b0;
                n_strand = 1'b0;
                n_start  = '0;
                n_end    = '0;
            end else if (extend) begin
                n_end = ext_end;
            end else begin
                n_valid  = 1'b1;
                n_strand = pos;
                n_start  = open_off;
                n_end    = open_off;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_strand <= 1'b0;
            r_start  <= '0;
            r_end    <= '0;
        end else begin
            r_valid  <= n_valid;
            r_strand <= n_strand;
            r_start  <= n_start;
            r_end    <= n_end;
        end
    end

endmodule

`default_nettype wire

/* design/dgr_queue.sv */
// Short record queue between front and back parts.
// Depends on dgr_pkg.
`default_nettype none

module dgr_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire dgr_pkg::t_rec i_rec,
    output logic               o_ready,
    input  wire logic          i_pop,
    output logic               o_valid,
    output dgr_pkg::t_rec      o_rec
);

    dgr_pkg::t_rec                r_mem [dgr_pkg::QDEPTH];
    logic [dgr_pkg::QPTR_W-1:0]   r_wptr;
    logic [dgr_pkg::QPTR_W-1:0]   r_rptr;
    logic [dgr_pkg::QPTR_W:0]     r_count;

    logic do_push;
    logic do_pop;

    assign o_ready = (r_count != (dgr_pkg::QPTR_W + 1)'(dgr_pkg::QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_rec   = r_mem[r_rptr];

    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    // Storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_rec;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

/* design/dgr_back.sv */
// Back part: emits the one or two ranges of each queue record in order.
// Depends on dgr_pkg.
`default_nettype none

module dgr_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_q_valid,
    input  wire dgr_pkg::t_rec i_rec,
    output logic               o_pop,
    output logic               o_valid,
    output dgr_pkg::t_out      o_data,
    input  wire logic          i_ready
);

    logic r_phase;   // 1: close range already sent, flush range next
    logic cur_close;
    logic take;

    assign cur_close = !r_phase && i_rec.has_close;
    assign o_valid   = i_q_valid;
    assign o_data    = cur_close ? i_rec.close_rng : i_rec.flush_rng;
    assign take      = o_valid && i_ready;
    assign o_pop     = take && !(cur_close && i_rec.has_flush);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= 1'b0;
        end else if (take) begin
            r_phase <= !o_pop;
        end
    end

endmodule

`default_nettype wire

/* design/delta_gap_run_decoder.sv */
// Delta gap run decoder: one delta item per cycle in while the queue has room, gap ranges out.
// Each item's ranges are registered in a queue record before they are offered; a close range goes before a flush range.
// Items are taken one per cycle; a two-range item leaves as two separate ranges, and
// the input stalls once the two-record queue between front and back fills.
// Reset (synchronous, active low) clears the pending run, offset and queue.
`default_nettype none

module delta_gap_run_decoder #(
    parameter int unsigned OFFSET_WIDTH = 32
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    dgr_stream.sink    i_item,
    dgr_stream.source  o_range
);

    logic          q_ready;
    logic          push;
    dgr_pkg::t_rec push_rec;
    logic          q_valid;
    dgr_pkg::t_rec head_rec;
    logic          pop;

    dgr_front #(
        .OFFSET_WIDTH (OFFSET_WIDTH)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_item.valid),
        .i_data    (i_item.data),
        .o_ready   (i_item.ready),
        .i_q_ready (q_ready),
        .o_push    (push),
        .o_rec     (push_rec)
    );

    dgr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_rec   (push_rec),
        .o_ready (q_ready),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_rec   (head_rec)
    );

    dgr_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_rec     (head_rec),
        .o_pop     (pop),
        .o_valid   (o_range.valid),
        .o_data    (o_range.data),
        .i_ready   (o_range.ready)
    );

endmodule

`default_nettype wire

/* design/dgr_checker.sv */
// Port-level checks for the delta gap run decoder, bound to the top level.
// Depends on dgr_pkg and delta_gap_run_decoder.
`default_nettype none

module dgr_checker (
    input wire logic          i_clk,
    input wire logic          i_rst_n,
    input wire logic          i_in_valid,
    input wire logic          i_in_ready,
    input wire logic          i_out_valid,
    input wire logic          i_out_ready,
    input wire dgr_pkg::t_out i_out_data
);

    // Reset empties the result path
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // A result appears only after an item was taken
    a_result_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(i_in_valid && i_in_ready))
        else $error("result without accepted item");

    // A stalled result holds its payload
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_data)))
        else $error("stalled result changed");

endmodule

bind delta_gap_run_decoder dgr_checker u_dgr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_item.valid),
    .i_in_ready  (i_item.ready),
    .i_out_valid (o_range.valid),
    .i_out_ready (o_range.ready),
    .i_out_data  (o_range.data)
);

`default_nettype wire

/* dv/delta_gap_run_decoder_tb.sv */
// Self-checking testbench for delta_gap_run_decoder: drives signed delta items,
// predicts the gap ranges in place and checks every range the block returns.
// Depends on dgr_pkg, the dgr_stream interface and the decoder RTL.

module delta_gap_run_decoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned OFFSET_WIDTH = 32;
    localparam longint unsigned POS_MAX = (64'd1 << OFFSET_WIDTH) - 64'd1;
    localparam int QUIET_LIMIT = 1000;    // cycles with no item moving on either side
    localparam int STALL_CYCLES = 60;     // long receiver hold-off
    localparam int PHASE_ITEMS = 565;

    logic i_clk;
    logic i_rst_n;

    dgr_stream #(.T(dgr_pkg::t_in))  item_if ();
    dgr_stream #(.T(dgr_pkg::t_out)) range_if ();

    delta_gap_run_decoder #(
        .OFFSET_WIDTH (OFFSET_WIDTH)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (item_if.sink),
        .o_range (range_if.source)
    );

    // Idle rates in percent, and the long receiver hold-off request
    int src_idle_pct = 16;
    int snk_idle_pct = 60;
    bit stall_request = 1'b0;
    int stall_left = 0;

    // Ranges still due from the block, oldest first
    dgr_pkg::t_out gap_ranges_due[$];
    int   mismatch_count = 0;
    int   quiet_cycles = 0;

    // Tracked decoder state
    longint unsigned trk_offset = 0;
    longint unsigned trk_start = 0;
    longint unsigned trk_len = 0;
    bit              trk_open = 1'b0;
    bit              trk_query = 1'b0;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // ---------------------------------------------------------------
    // Gap range prediction
    // ---------------------------------------------------------------
    function automatic longint unsigned sat_sum(longint unsigned a, longint unsigned b);
        if (a > POS_MAX) a = POS_MAX;
        if (b > POS_MAX - a) return POS_MAX;
        return a + b;
    endfunction

    function automatic void push_range(bit strand, longint unsigned first,
                                       longint unsigned last_pos, bit is_final);
        dgr_pkg::t_out r;
        r.gap_strand = strand;
        r.gap_start  = first[31:0];
        r.gap_end    = last_pos[31:0];
        r.last_range = is_final;
        gap_ranges_due = {gap_ranges_due, r};
    endfunction

    function automatic void predict_ranges(dgr_pkg::t_in it);
        logic [31:0]     raw;
        logic [31:0]     neg_raw;
        longint unsigned mag;
        longint unsigned run_end;
        bit              is_neg;
        bit              is_pos;
        bit              grows;
        raw     = it.delta_value;
        neg_raw = ~raw + 32'd1;
        is_neg  = raw[31];
        is_pos  = !is_neg && (raw != 32'd0);
        if (is_neg) mag = 64'(neg_raw);
        else        mag = 64'(raw);
        // +1 extends a query run, -1 extends a reference run
        grows = trk_open && ((raw == 32'd1 && trk_query) ||
                             (raw == 32'hFFFF_FFFF && !trk_query));
        if (grows) begin
            trk_len = sat_sum(trk_len, 64'd1);
        end else begin
            // close the pending run, then open one for this delta
            if (trk_open) begin
                run_end = sat_sum(trk_start, trk_len);
                push_range(trk_query, trk_start, run_end, 1'b0);
                trk_offset = run_end;
            end
            trk_offset = sat_sum(trk_offset, mag);
            trk_open   = 1'b1;
            trk_query  = is_pos;
            trk_start  = trk_offset;
            trk_len    = 0;
        end
        // end of entry: flush and start fresh
        if (it.is_last) begin
            run_end = sat_sum(trk_start, trk_len);
            push_range(trk_query, trk_start, run_end, 1'b1);
            trk_offset = 0;
            trk_open   = 1'b0;
            trk_query  = 1'b0;
            trk_start  = 0;
            trk_len    = 0;
        end
    endfunction

    function automatic void check_range(dgr_pkg::t_out want, dgr_pkg::t_out got);
        if (got.gap_strand !== want.gap_strand) begin
            $display("%0t mismatch gap_strand: expected %0d actual %0d",
                     $realtime, want.gap_strand, got.gap_strand);
            mismatch_count++;
        end
        if (got.gap_start !== want.gap_start) begin
            $display("%0t mismatch gap_start: expected %h actual %h",
                     $realtime, want.gap_start, got.gap_start);
            mismatch_count++;
        end
        if (got.gap_end !== want.gap_end) begin
            $display("%0t mismatch gap_end: expected %h actual %h",
                     $realtime, want.gap_end, got.gap_end);
            mismatch_count++;
        end
        if (got.last_range !== want.last_range) begin
            $display("%0t mismatch last_range: expected %0d actual %0d",
                     $realtime, want.last_range, got.last_range);
            mismatch_count++;
        end
    endfunction

    // ---------------------------------------------------------------
    // Result check, input tracking and watchdog at the rising edge
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (range_if.valid && range_if.ready) begin
                if (gap_ranges_due.size() == 0) begin
                    $display("%0t unexpected range: expected none actual %p",
                             $realtime, range_if.data);
                    mismatch_count++;
                end else begin
                    check_range(gap_ranges_due.pop_front(), range_if.data);
                end
            end
            if (item_if.valid && item_if.ready)
                predict_ranges(item_if.data);
            if ((range_if.valid && range_if.ready) || (item_if.valid && item_if.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("%0t watchdog: no item moved for %0d cycles", $realtime, quiet_cycles);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------
    // Range receiver: random stalls, plus a long hold-off on request
    // ---------------------------------------------------------------
    initial range_if.ready = 1'b0;

    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            range_if.ready <= 1'b0;
        end else if (stall_request) begin
            stall_request = 1'b0;
            stall_left = STALL_CYCLES - 1;
            range_if.ready <= 1'b0;
        end else begin
            range_if.ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    // ---------------------------------------------------------------
    // Item sender; called and returning at a falling edge, valid left
    // high so back-to-back items need no drop in between
    // ---------------------------------------------------------------
    initial begin
        item_if.valid = 1'b0;
        item_if.data  = '0;
    end

    task automatic send_delta(input logic signed [31:0] d, input logic last);
        while ($urandom_range(99) < src_idle_pct) begin
            item_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        item_if.valid <= 1'b1;
        item_if.data  <= '{delta_value: d, is_last: last};
        @(posedge i_clk);
        while (!item_if.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Sender pause until every predicted range has come back
    task automatic wait_ranges_drained();
        item_if.valid <= 1'b0;
        wait (gap_ranges_due.size() == 0);
        @(negedge i_clk);
    endtask

    // One entry of random deltas; the final one carries the last flag
    task automatic send_random_entry(input int len, input bit far_jumps);
        logic signed [31:0] d;
        int                 pick;
        bit                 unit_down;
        unit_down = 1'($urandom_range(1));
        for (int k = 0; k < len; k++) begin
            pick = $urandom_range(99);
            if (far_jumps) begin
                // big steps that push the offset into saturation
                d = $urandom_range(32'h7FFF_FFFF, 32'h2000_0000);
                if ($urandom_range(1)) d = -d;
            end else if (pick < 40) begin
                // unit steps, mostly of one sign so runs grow
                if ($urandom_range(99) < 25) unit_down = !unit_down;
                d = unit_down ? -32'sd1 : 32'sd1;
            end else if (pick < 50) begin
                d = 32'sd0;
            end else if (pick < 80) begin
                d = $signed($urandom_range(40)) - 20;
            end else if (pick < 92) begin
                d = $urandom_range(65535);
                if ($urandom_range(1)) d = -d;
            end else begin
                d = $urandom();
            end
            send_delta(d, k == len - 1);
        end
    endtask

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------
    task automatic test_directed_cases();
        // single-item entry
        send_delta(32'sd5, 1'b1);
        // zero delta opens a reference run, -1 extends it, +1 closes it
        send_delta(32'sd0, 1'b0);
        send_delta(-32'sd1, 1'b0);
        send_delta(-32'sd1, 1'b0);
        send_delta(32'sd1, 1'b0);
        send_delta(32'sd1, 1'b0);
        send_delta(-32'sd1, 1'b0);
        send_delta(32'sd1, 1'b1);
        // unit delta with no run pending
        send_delta(32'sd1, 1'b0);
        send_delta(-32'sd1, 1'b1);
        // largest deltas drive the offset into saturation
        send_delta(32'sh7FFF_FFFF, 1'b0);
        send_delta(32'sh7FFF_FFFF, 1'b0);
        send_delta(32'sh7FFF_FFFF, 1'b0);
        send_delta(32'sd1, 1'b0);
        send_delta(32'sd1, 1'b0);
        send_delta(32'sh8000_0000, 1'b0);
        send_delta(32'sh8000_0001, 1'b1);
        // most negative delta opening an entry
        send_delta(32'sh8000_0000, 1'b1);
        // zero delta on a last item, then a lone -1
        send_delta(32'sd0, 1'b1);
        send_delta(-32'sd1, 1'b1);
        // mixed signs, last item opens a fresh run after closing one
        send_delta(-32'sd7, 1'b0);
        send_delta(32'sd3, 1'b1);
        wait_ranges_drained();
    endtask

    task automatic test_output_stall_fill();
        src_idle_pct = 0;
        snk_idle_pct = 0;
        stall_request = 1'b1;
        // keep offering while the receiver holds off, so the input stalls
        for (int k = 0; k < 10; k++) send_random_entry(3, 1'b0);
        wait_ranges_drained();
    endtask

    task automatic test_random_entries(input int item_goal, input int src_pct,
                                       input int snk_pct);
        int sent;
        int len;
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
        sent = 0;
        while (sent < item_goal) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 1);
            send_random_entry(len, $urandom_range(9) == 0);
            sent += len;
        end
        wait_ranges_drained();
    endtask

    // ---------------------------------------------------------------
    // Sequence
    // ---------------------------------------------------------------
    initial begin
        i_rst_n = 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed_cases();
        test_random_entries(PHASE_ITEMS, 16, 60);
        test_random_entries(PHASE_ITEMS, 60, 16);
        test_output_stall_fill();
        test_random_entries(PHASE_ITEMS, 0, 0);

        // allow any stray range to show up
        repeat (4) @(posedge i_clk);
        if (mismatch_count == 0 && gap_ranges_due.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
